FILE: rtl/assert_macros.svh
// Assertion helpers shared by the circle point generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  localparam int COORD_W   = 10;
  localparam int RADIUS_W  = 8;
  localparam int OUT_W     = 11;
  localparam int SQ_W      = 2 * RADIUS_W;

  // program layout: wait, square, RADIUS_W root steps, four point steps
  localparam int ROOT_BASE = 2;
  localparam int EMIT_BASE = ROOT_BASE + RADIUS_W;
  localparam int PROG_LEN  = EMIT_BASE + 4;
  localparam int PC_W      = $clog2(PROG_LEN);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_SQD,
    OP_ROOT,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_t;

  typedef struct packed {
    op_t        op;
    wait_t      waitc;
    logic       jump;
    pc_t        target;
    logic [1:0] sel;
    logic       last;
  } ctl_t;

  typedef struct packed {
    logic go;
    logic slot_free;
  } seq_stat_t;

  // microcode ROM
  function automatic ctl_t prog_word(input int idx);
    ctl_t w;
    w.op     = OP_WAIT;
    w.waitc  = WAIT_NONE;
    w.jump   = 1'b0;
    w.target = '0;
    w.sel    = 2'd0;
    w.last   = 1'b0;
    if (idx == 0) begin
      w.waitc = WAIT_IN;
    end else if (idx == 1) begin
      w.op = OP_SQD;
    end else if (idx < EMIT_BASE) begin
      w.op = OP_ROOT;
    end else if (idx < PROG_LEN) begin
      w.op    = OP_EMIT;
      w.waitc = WAIT_OUT;
      w.sel   = 2'(idx - EMIT_BASE);
      if (idx == PROG_LEN - 1) begin
        w.last = 1'b1;
        w.jump = 1'b1;
      end
    end else begin
      w.jump = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [OUT_W-1:0] fit_out(input logic [COORD_W:0] v);
    logic [COORD_W+OUT_W:0] wide;
    wide = {{OUT_W{1'b0}}, v};
    return wide[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cpg_useq.sv
`default_nettype none
`include "assert_macros.svh"

module cpg_useq
  import cpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire seq_stat_t stat,
  output ctl_t           ctl
);

  pc_t  pc;
  pc_t  pc_next;
  logic advance;

  assign ctl = prog_word(int'(pc));

  always_comb begin
    case (ctl.waitc)
      WAIT_IN:  advance = stat.go;
      WAIT_OUT: advance = stat.slot_free;
      default:  advance = 1'b1;
    endcase
    if (!advance) begin
      pc_next = pc;
    end else if (ctl.jump) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  `ASSERT_CLK(a_pc_range, 1'b1 |-> ({1'b0, pc} < (PC_W+1)'(PROG_LEN)), "pc left the program")

endmodule

`default_nettype wire

FILE: rtl/cpg_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module cpg_dpath
  import cpg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_t                ctl,
  input  wire logic                in_fire,
  input  wire logic                kind,
  input  wire logic [COORD_W-1:0]  centre_x,
  input  wire logic [COORD_W-1:0]  centre_y,
  input  wire logic [RADIUS_W-1:0] radius,
  input  wire logic                slot_free,
  output logic                     go,
  output logic [OUT_W-1:0]         pt_x,
  output logic [OUT_W-1:0]         pt_y,
  output logic                     pt_done
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COL,
    PH_ROW
  } phase_t;

  phase_t              phase;
  logic [COORD_W-1:0]  walk_pos;
  logic [COORD_W-1:0]  held_cx;
  logic [COORD_W-1:0]  held_cy;
  logic [RADIUS_W-1:0] held_r;

  // root unit
  logic [RADIUS_W-1:0] dd;
  logic [SQ_W-1:0]     acc;
  logic [SQ_W-1:0]     res;
  logic [SQ_W-1:0]     bitm;

  logic                col;
  logic [COORD_W-1:0]  along;
  logic [COORD_W-1:0]  other;
  logic [COORD_W-1:0]  dpos;
  logic [SQ_W-1:0]     rsq;
  logic [SQ_W-1:0]     dsq;
  logic [SQ_W:0]       trial;
  logic                fits;
  logic [RADIUS_W-1:0] fl;
  logic [RADIUS_W:0]   cl;
  logic [COORD_W:0]    hi;
  logic [COORD_W-1:0]  lo;
  logic [COORD_W:0]    mir;
  logic [COORD_W:0]    walk_ext;
  logic [COORD_W:0]    lo_ext;
  logic                final_step;
  logic                row_ok;
  logic                col_ok;
  logic                step_end;

  assign col    = (phase == PH_COL);
  assign along  = col ? held_cx : held_cy;
  assign other  = col ? held_cy : held_cx;
  assign dpos   = along - walk_pos;
  assign rsq    = SQ_W'(held_r) * SQ_W'(held_r);
  assign dsq    = SQ_W'(dd) * SQ_W'(dd);
  assign trial  = {1'b0, res} + {1'b0, bitm};
  assign fits   = ({1'b0, acc} >= trial);
  assign row_ok = (held_cy >= COORD_W'(held_r));
  assign col_ok = (centre_x >= COORD_W'(radius));

  assign go = in_fire && kind && (phase == PH_COL || phase == PH_ROW);

  // point arithmetic; remainder nonzero means s was not a perfect square
  assign fl       = res[RADIUS_W-1:0];
  assign cl       = {1'b0, fl} + (RADIUS_W+1)'(|acc);
  assign hi       = {1'b0, other} + (COORD_W+1)'(fl);
  assign lo       = ({1'b0, other} >= (COORD_W+1)'(cl)) ?
                    (other - COORD_W'(cl)) : '0;
  assign mir      = {along, 1'b0} - {1'b0, walk_pos};
  assign walk_ext = {1'b0, walk_pos};
  assign lo_ext   = {1'b0, lo};

  assign final_step = (walk_pos >= along);
  assign step_end   = (ctl.op == OP_EMIT) && ctl.last && slot_free;
  assign pt_done    = ctl.last && final_step && !(col && row_ok);

  always_comb begin
    case ({col, ctl.sel})
      3'b100:  begin pt_x = fit_out(walk_ext); pt_y = fit_out(hi);       end
      3'b101:  begin pt_x = fit_out(walk_ext); pt_y = fit_out(lo_ext);   end
      3'b110:  begin pt_x = fit_out(mir);      pt_y = fit_out(hi);       end
      3'b111:  begin pt_x = fit_out(mir);      pt_y = fit_out(lo_ext);   end
      3'b000:  begin pt_x = fit_out(hi);       pt_y = fit_out(walk_ext); end
      3'b001:  begin pt_x = fit_out(lo_ext);   pt_y = fit_out(walk_ext); end
      3'b010:  begin pt_x = fit_out(hi);       pt_y = fit_out(mir);      end
      default: begin pt_x = fit_out(lo_ext);   pt_y = fit_out(mir);      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      walk_pos <= '0;
      held_cx  <= '0;
      held_cy  <= '0;
      held_r   <= '0;
    end else begin
      if (in_fire && !kind) begin
        held_cx <= centre_x;
        held_cy <= centre_y;
        held_r  <= radius;
        if (col_ok) begin
          phase    <= PH_COL;
          walk_pos <= centre_x - COORD_W'(radius);
        end else if (centre_y >= COORD_W'(radius)) begin
          phase    <= PH_ROW;
          walk_pos <= centre_y - COORD_W'(radius);
        end else begin
          phase <= PH_IDLE;
        end
      end
      if (step_end) begin
        if (!final_step) begin
          walk_pos <= walk_pos + 1'b1;
        end else if (col && row_ok) begin
          phase    <= PH_ROW;
          walk_pos <= held_cy - COORD_W'(held_r);
        end else begin
          phase <= PH_IDLE;
        end
      end
    end

    // root unit, payload only
    if (go) begin
      dd  <= dpos[RADIUS_W-1:0];
      acc <= rsq;
    end
    if (ctl.op == OP_SQD) begin
      acc  <= acc - dsq;
      res  <= '0;
      bitm <= SQ_W'(1) << (SQ_W - 2);
    end
    if (ctl.op == OP_ROOT) begin
      if (fits) begin
        acc <= acc - trial[SQ_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  `ASSERT_CLK(a_root_bit, (ctl.op == OP_ROOT) |-> $onehot(bitm), "root bit not one-hot")
  `ASSERT_CLK(a_emit_active, (ctl.op == OP_EMIT) |-> (phase == PH_COL || phase == PH_ROW), "emit while idle")

endmodule

`default_nettype wire

FILE: rtl/circle_point_generator.sv
`default_nettype none
`include "assert_macros.svh"

// Circle point generator. A start beat (kind = 0) latches centre and radius
// and produces no points; each step beat (kind = 1) then produces four
// mirrored points of the circle, first walking columns from centre_x-radius
// up to centre_x, then rows the same way. Each point's offset comes from an
// exact integer square root of r*r-d*d; the lower point is clamped at zero.
// A phase is skipped when its centre coordinate is below the radius. The
// fourth point of a step carries last_of_step, and the final point of the
// circle also carries circle_done. A step beat while no circle is active,
// and a start beat, are taken without leaving the wait step. A step beat
// with a circle active runs an accept step, a step to form r*r-d*d, one
// step per root bit pair (8, set by the shared shift-subtract root unit),
// then one point per cycle through the output register while it is free.
// A small microcode ROM steps the datapath; in_ready is high only
// on its wait step, so a new beat is taken while the last point still sits
// in the output register.

module circle_point_generator
  import cpg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                kind,
  input  wire logic [COORD_W-1:0]  centre_x,
  input  wire logic [COORD_W-1:0]  centre_y,
  input  wire logic [RADIUS_W-1:0] radius,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [OUT_W-1:0]         point_x,
  output logic [OUT_W-1:0]         point_y,
  output logic                     last_of_step,
  output logic                     circle_done
);

  ctl_t             ctl;
  seq_stat_t        stat;
  logic             in_fire;
  logic             slot_free;
  logic             go;
  logic             load;
  logic [OUT_W-1:0] pt_x;
  logic [OUT_W-1:0] pt_y;
  logic             pt_done;

  assign in_ready  = (ctl.waitc == WAIT_IN);
  assign in_fire   = in_valid && in_ready;
  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid || out_ready;
  assign load      = (ctl.op == OP_EMIT) && slot_free;

  assign stat.go        = go;
  assign stat.slot_free = slot_free;

  cpg_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  cpg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_fire   (in_fire),
    .kind      (kind),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .radius    (radius),
    .slot_free (slot_free),
    .go        (go),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .pt_done   (pt_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      point_x      <= pt_x;
      point_y      <= pt_y;
      last_of_step <= ctl.last;
      circle_done  <= pt_done;
    end
  end

  `ASSERT_CLK(a_done_last, out_valid && circle_done |-> last_of_step, "done without last")
  `ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_no_load_idle, in_ready |-> !load, "point loaded on wait step")

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

// Testbench for circle_point_generator.
// A start beat latches centre and radius. Each step beat then gives four
// mirrored points: first the column walk, then the row walk. The
// circle_tracker class below predicts every point on its own and checks each
// output beat against the oldest point still waiting.
// The stimulus has two parts. A short directed part covers the extremes and
// the special cases. The random part is mostly whole circles, some cut short
// and some overrun, mixed with noise beats.

module tb;
  import cpg_pkg::*;

  // beat kinds on the input channel
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  localparam int RANDOM_BEATS = 430;
  localparam int DRAIN_CYCLES = 40;      // longer than one step takes, so plenty
  localparam int CYCLE_LIMIT  = 400000;  // the slowest correct run is far below

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_COL,
    WALK_ROW
  } walk_t;

  typedef struct {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic             last;
    logic             done;
  } point_t;

  // predictor and point store
  class circle_tracker;
    walk_t                walk;
    logic [COORD_W-1:0]   pos;
    logic [COORD_W-1:0]   hold_cx;
    logic [COORD_W-1:0]   hold_cy;
    logic [RADIUS_W-1:0]  hold_r;
    point_t               waiting[$];
    int                   errors;

    function new();
      walk    = WALK_IDLE;
      pos     = '0;
      hold_cx = '0;
      hold_cy = '0;
      hold_r  = '0;
      errors  = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("tb: mismatch: %s", msg);
    endfunction

    // bitwise integer square root, rounded down
    function int unsigned root_down(int unsigned v);
      int unsigned acc = 0;
      int unsigned t;
      for (int b = 7; b >= 0; b--) begin
        t = acc | (1 << b);
        if (t * t <= v) acc = t;
      end
      return acc;
    endfunction

    function void start_rows();
      if (hold_cy >= hold_r) begin
        walk = WALK_ROW;
        pos  = hold_cy - hold_r;
      end else begin
        walk = WALK_IDLE;
      end
    endfunction

    function void push_point(int unsigned x, int unsigned y, logic last, logic done);
      point_t p;
      p.x    = x[OUT_W-1:0];
      p.y    = y[OUT_W-1:0];
      p.last = last;
      p.done = done;
      waiting.push_back(p);
    endfunction

    // note an accepted input beat and predict the points it causes
    function void note_beat(logic k, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                            logic [RADIUS_W-1:0] r);
      int unsigned along, other, c, d, rr, s, fl, cl, hi, lo, mir;
      logic        col, final_step, done;
      if (k == KIND_START) begin
        hold_cx = cx;
        hold_cy = cy;
        hold_r  = r;
        if (cx >= r) begin
          walk = WALK_COL;
          pos  = cx - r;
        end else begin
          start_rows();
        end
        return;
      end
      if (walk == WALK_IDLE) return;

      col   = (walk == WALK_COL);
      along = col ? hold_cx : hold_cy;
      other = col ? hold_cy : hold_cx;
      rr    = hold_r;
      c     = pos;
      d     = (along >= c) ? along - c : 0;
      s     = (d <= rr) ? rr * rr - d * d : 0;
      fl    = root_down(s);
      cl    = (fl * fl != s) ? fl + 1 : fl;
      hi    = other + fl;
      lo    = (other >= cl) ? other - cl : 0;   // lower point clamps at zero
      mir   = 2 * along - c;

      final_step = (c >= along);
      if (final_step) begin
        if (col) start_rows();
        else walk = WALK_IDLE;
      end else begin
        pos = pos + 1'b1;
      end
      done = final_step && (walk == WALK_IDLE);

      if (col) begin
        push_point(c, hi, 1'b0, 1'b0);
        push_point(c, lo, 1'b0, 1'b0);
        push_point(mir, hi, 1'b0, 1'b0);
        push_point(mir, lo, 1'b1, done);
      end else begin
        push_point(hi, c, 1'b0, 1'b0);
        push_point(lo, c, 1'b0, 1'b0);
        push_point(hi, mir, 1'b0, 1'b0);
        push_point(lo, mir, 1'b1, done);
      end
    endfunction

    function void check_point(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y, logic last,
                              logic done);
      point_t p;
      if (waiting.size() == 0) begin
        report($sformatf("point (%0d,%0d) with none predicted", x, y));
        return;
      end
      p = waiting.pop_front();
      if (x !== p.x || y !== p.y || last !== p.last || done !== p.done)
        report($sformatf("got x=%0d y=%0d last=%b done=%b, want x=%0d y=%0d last=%b done=%b",
                         x, y, last, done, p.x, p.y, p.last, p.done));
    endfunction

    function int outstanding();
      return waiting.size();
    endfunction

    function void close_out();
      if (waiting.size() != 0)
        report($sformatf("%0d predicted points never came out", waiting.size()));
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                kind;
  logic [COORD_W-1:0]  centre_x;
  logic [COORD_W-1:0]  centre_y;
  logic [RADIUS_W-1:0] radius;
  logic                out_valid;
  logic                out_ready;
  logic [OUT_W-1:0]    point_x;
  logic [OUT_W-1:0]    point_y;
  logic                last_of_step;
  logic                circle_done;

  circle_tracker board;
  int            send_idle_pct;   // chance of a gap before each input beat
  int            stall_pct;       // chance the receiver holds off in a cycle
  int            beats_sent;
  int            cycles;

  circle_point_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .radius       (radius),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random back-pressure, one draw per cycle
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // output monitor; values read here are the ones sampled at this edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_point(point_x, point_y, last_of_step, circle_done);
  end

  // Drive one beat and hold it until taken. Valid stays high across
  // back-to-back beats, so each step sees only one assignment to it.
  task automatic send_beat(logic k, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [RADIUS_W-1:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    centre_x <= cx;
    centre_y <= cy;
    radius   <= r;
    do @(posedge clk); while (!in_ready);
    board.note_beat(k, cx, cy, r);
    beats_sent++;
  endtask

  task automatic step_beats(int n);
    repeat (n) send_beat(KIND_STEP, COORD_W'($urandom), COORD_W'($urandom),
                         RADIUS_W'($urandom));
  endtask

  // one start beat followed by a whole, cut, or overrun walk
  task automatic random_circle();
    logic [COORD_W-1:0]  cx, cy;
    logic [RADIUS_W-1:0] r;
    int                  full, n;
    cx = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 20))
                                     : COORD_W'($urandom);
    cy = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom_range(0, 20))
                                     : COORD_W'($urandom);
    case ($urandom_range(0, 19))
      0:       r = RADIUS_W'($urandom);              // large, walk gets cut
      1, 2:    r = RADIUS_W'($urandom_range(13, 40));
      default: r = RADIUS_W'($urandom_range(0, 12));
    endcase
    full = ((cx >= r) ? r + 1 : 0) + ((cy >= r) ? r + 1 : 0);
    n = full;
    case ($urandom_range(0, 7))
      0, 1: n = $urandom_range(0, full);             // abandoned by next start
      2:    n = full + $urandom_range(1, 2);         // steps after the end
      default: ;
    endcase
    if (r > 40 && n > 30) n = $urandom_range(1, 30);
    send_beat(KIND_START, cx, cy, r);
    step_beats(n);
  endtask

  initial begin
    board         = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_START;
    centre_x      = '0;
    centre_y      = '0;
    radius        = '0;
    out_ready     = 1'b0;
    cycles        = 0;
    beats_sent    = 0;
    send_idle_pct = 26;
    stall_pct     = 86;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    step_beats(1);                                    // step with no circle
    send_beat(KIND_START, '0, '0, '0);                // zero radius at origin
    step_beats(2);
    send_beat(KIND_START, '1, '1, '1);                // all ones, widest radius
    step_beats(3);
    send_beat(KIND_START, 10'd20, 10'd2, 8'd10);      // low points clamp to zero
    step_beats(4);
    send_beat(KIND_START, 10'd3, 10'd500, 8'd10);     // column walk skipped
    step_beats(2);
    send_beat(KIND_START, 10'd2, 10'd2, 8'd5);        // both walks skipped
    step_beats(1);
    send_beat(KIND_START, '1, '0, 8'd1);              // row walk skipped
    step_beats(3);                                    // last one hits idle

    // random part: three idling profiles by thirds
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent < RANDOM_BEATS / 3) begin
        send_idle_pct = 26;
        stall_pct     = 86;
      end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 86;
        stall_pct     = 26;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      if ($urandom_range(0, 9) < 8) begin
        random_circle();
      end else begin
        repeat ($urandom_range(1, 4))
          send_beat(1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    RADIUS_W'($urandom));
      end
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/cpg_pkg.sv
rtl/cpg_useq.sv
rtl/cpg_dpath.sv
rtl/circle_point_generator.sv
test/tb.sv
